FILE: rtl/core/upaq_pkg.sv
// ----------------------------------------------------------------------------
// upaq_pkg
// Shared types, request/status codes and default sizes for the unsorted
// array priority queue.
// ----------------------------------------------------------------------------
package upaq_pkg;

  // Default sizes
  localparam int DEPTH_DEF         = 8;
  localparam int VALUE_BITS_DEF    = 32;
  localparam int PRIORITY_BITS_DEF = 16;

  // Request codes
  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_REMOVE = 2'd1;
  localparam logic [1:0] KIND_PEEK   = 2'd2;

  // Result status codes
  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // Controller states
  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_t;

  // Request transaction
  typedef struct packed {
    logic [1:0]          kind;
    logic signed [31:0]  in_value;
    logic signed [15:0]  in_priority;
  } req_t;

  // Response transaction
  typedef struct packed {
    logic [1:0]          status;
    logic signed [31:0]  out_value;
    logic [3:0]          entry_count;
    logic                is_empty;
  } rsp_t;

  // Per-cell control from the controller
  typedef struct packed {
    logic occupied;
    logic load;
    logic shift;
  } cell_ctrl_t;

endpackage

FILE: rtl/core/upaq_cell.sv
// ----------------------------------------------------------------------------
// upaq_cell
// One slot of the queue: holds a value and priority, takes a new entry or
// its right neighbor's entry, and forwards the best candidate seen so far
// one cell to the right each cycle.
// ----------------------------------------------------------------------------
module upaq_cell #(
  parameter int VALUE_BITS    = upaq_pkg::VALUE_BITS_DEF,
  parameter int PRIORITY_BITS = upaq_pkg::PRIORITY_BITS_DEF,
  parameter int IDX_W         = 3,
  parameter int INDEX         = 0
) (
  input  logic                       clk,
  input  logic                       rst,
  input  upaq_pkg::cell_ctrl_t       ctrl,
  input  logic [VALUE_BITS-1:0]      load_value,
  input  logic [PRIORITY_BITS-1:0]   load_prio,
  input  logic [VALUE_BITS-1:0]      next_value,
  input  logic [PRIORITY_BITS-1:0]   next_prio,
  output logic [VALUE_BITS-1:0]      value,
  output logic [PRIORITY_BITS-1:0]   prio,
  input  logic                       cand_have_in,
  input  logic [PRIORITY_BITS-1:0]   cand_prio_in,
  input  logic [VALUE_BITS-1:0]      cand_value_in,
  input  logic [IDX_W-1:0]           cand_idx_in,
  output logic                       cand_have,
  output logic [PRIORITY_BITS-1:0]   cand_prio,
  output logic [VALUE_BITS-1:0]      cand_value,
  output logic [IDX_W-1:0]           cand_idx
);
  import upaq_pkg::*;

  logic take;

  // Hold entry: load a new one or pull the right neighbor's on a remove
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      value <= load_value;
      prio  <= load_prio;
    end else if (ctrl.shift) begin
      value <= next_value;
      prio  <= next_prio;
    end
  end

  // Replace the candidate only on a strictly greater priority, so the
  // earliest entry wins ties
  assign take = ctrl.occupied &&
                (!cand_have_in || ($signed(prio) > $signed(cand_prio_in)));

  // Advance the candidate one cell
  always_ff @(posedge clk) begin
    if (rst) begin
      cand_have <= 1'b0;
    end else begin
      cand_have <= cand_have_in || ctrl.occupied;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cand_prio  <= prio;
      cand_value <= value;
      cand_idx   <= IDX_W'(INDEX);
    end else begin
      cand_prio  <= cand_prio_in;
      cand_value <= cand_value_in;
      cand_idx   <= cand_idx_in;
    end
  end

endmodule

FILE: rtl/core/unsorted_array_priority_queue.sv
// ----------------------------------------------------------------------------
// unsorted_array_priority_queue
// Bounded priority queue kept in arrival order in a row of cells.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid/req_ready/req) carries insert, remove or peek
//   transactions; rsp channel (rsp_valid/rsp_ready/rsp) returns exactly one
//   result per request, with status, value, count and empty flag.
//   Insert, unknown kinds, insert when full and remove/peek when empty
//   answer in the cycle after acceptance. Remove and peek on a non-empty
//   queue first scan: the best candidate walks the cell row one cell per
//   cycle, and the answer is registered when the scan ends with the
//   response register free. A remove shifts all later cells as it ends.
//   Throughput: one request at a time; the next is accepted as soon as the
//   controller is idle and the response register is empty or being taken.
//   Reset clears the entry count and empties the response register; cell
//   contents stay undefined until written. When the receiver stalls the
//   response is held and no new request is accepted.
// ----------------------------------------------------------------------------
module unsorted_array_priority_queue #(
  parameter int DEPTH         = upaq_pkg::DEPTH_DEF,
  parameter int VALUE_BITS    = upaq_pkg::VALUE_BITS_DEF,
  parameter int PRIORITY_BITS = upaq_pkg::PRIORITY_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_ready,
  input  upaq_pkg::req_t  req,
  output logic            rsp_valid,
  input  logic            rsp_ready,
  output upaq_pkg::rsp_t  rsp
);
  import upaq_pkg::*;

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  state_t              state, state_next;
  logic [CNT_W-1:0]    count, count_next;
  logic [IDX_W-1:0]    scan_cnt;
  logic                op_remove;
  rsp_t                rsp_next;

  logic req_fire, out_free, scan_go, finish, ins_go, rem_go;
  logic is_ins, is_look, full, empty;

  logic [VALUE_BITS-1:0]    load_value;
  logic [PRIORITY_BITS-1:0] load_prio;
  logic [VALUE_BITS-1:0]    cell_value [DEPTH];
  logic [PRIORITY_BITS-1:0] cell_prio  [DEPTH];
  logic                     cand_have  [DEPTH];
  logic [PRIORITY_BITS-1:0] cand_prio  [DEPTH];
  logic [VALUE_BITS-1:0]    cand_value [DEPTH];
  logic [IDX_W-1:0]         cand_idx   [DEPTH];

  // Decode request
  assign req_fire = req_valid && req_ready;
  assign out_free = !rsp_valid || rsp_ready;
  assign is_ins   = (req.kind == KIND_INSERT);
  assign is_look  = (req.kind == KIND_REMOVE) || (req.kind == KIND_PEEK);
  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_fire && is_look && !empty) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (finish) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Controller outputs
  always_comb begin
    req_ready = 1'b0;
    finish    = 1'b0;
    unique case (state)
      S_IDLE: req_ready = out_free;
      S_SCAN: finish    = (scan_cnt == IDX_W'(DEPTH - 1)) && out_free;
      default: begin
        req_ready = 1'b0;
        finish    = 1'b0;
      end
    endcase
  end

  assign scan_go = req_fire && is_look && !empty;
  assign ins_go  = req_fire && is_ins && !full;
  assign rem_go  = finish && op_remove;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Count scan cycles while the candidate crosses the row
  always_ff @(posedge clk) begin
    if (scan_go) begin
      scan_cnt  <= '0;
      op_remove <= (req.kind == KIND_REMOVE);
    end else if (state == S_SCAN && scan_cnt != IDX_W'(DEPTH - 1)) begin
      scan_cnt <= scan_cnt + 1'b1;
    end
  end

  // Track fill count
  always_comb begin
    count_next = count;
    if (ins_go) begin
      count_next = count + 1'b1;
    end else if (rem_go) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // Convert incoming fields to stored widths
  assign load_value = VALUE_BITS'(req.in_value);
  assign load_prio  = PRIORITY_BITS'(req.in_priority);

  // Row of cells
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    cell_ctrl_t               ctrl;
    logic                     have_in;
    logic [PRIORITY_BITS-1:0] prio_in;
    logic [VALUE_BITS-1:0]    value_in;
    logic [IDX_W-1:0]         idx_in;
    logic [VALUE_BITS-1:0]    nxt_value;
    logic [PRIORITY_BITS-1:0] nxt_prio;

    assign ctrl.occupied = (CNT_W'(i) < count);
    assign ctrl.load     = ins_go && (count == CNT_W'(i));
    assign ctrl.shift    = rem_go && (IDX_W'(i) >= cand_idx[DEPTH-1]) &&
                           ((CNT_W'(i) + 1'b1) < count);

    if (i == 0) begin : g_head
      assign have_in  = 1'b0;
      assign prio_in  = '0;
      assign value_in = '0;
      assign idx_in   = '0;
    end else begin : g_body
      assign have_in  = cand_have[i-1];
      assign prio_in  = cand_prio[i-1];
      assign value_in = cand_value[i-1];
      assign idx_in   = cand_idx[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign nxt_value = cell_value[i];
      assign nxt_prio  = cell_prio[i];
    end else begin : g_link
      assign nxt_value = cell_value[i+1];
      assign nxt_prio  = cell_prio[i+1];
    end

    upaq_cell #(
      .VALUE_BITS   (VALUE_BITS),
      .PRIORITY_BITS(PRIORITY_BITS),
      .IDX_W        (IDX_W),
      .INDEX        (i)
    ) u_cell (
      .clk          (clk),
      .rst          (rst),
      .ctrl         (ctrl),
      .load_value   (load_value),
      .load_prio    (load_prio),
      .next_value   (nxt_value),
      .next_prio    (nxt_prio),
      .value        (cell_value[i]),
      .prio         (cell_prio[i]),
      .cand_have_in (have_in),
      .cand_prio_in (prio_in),
      .cand_value_in(value_in),
      .cand_idx_in  (idx_in),
      .cand_have    (cand_have[i]),
      .cand_prio    (cand_prio[i]),
      .cand_value   (cand_value[i]),
      .cand_idx     (cand_idx[i])
    );
  end

  // Build response
  always_comb begin
    rsp_next.status      = ST_DONE;
    rsp_next.out_value   = '0;
    rsp_next.entry_count = 4'(count_next);
    rsp_next.is_empty    = (count_next == '0);
    if (finish) begin
      rsp_next.out_value = 32'($signed(cand_value[DEPTH-1]));
    end else if (is_ins && full) begin
      rsp_next.status = ST_FULL;
    end else if (is_look && empty) begin
      rsp_next.status = ST_EMPTY;
    end
  end

  // Hold response until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if ((req_fire && !scan_go) || finish) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((req_fire && !scan_go) || finish) begin
      rsp <= rsp_next;
    end
  end

`ifndef NO_ASSERTIONS
  // Candidate at the tail must be a real entry when the scan ends
  a_tail_found: assert property (@(posedge clk) disable iff (rst)
    finish |-> cand_have[DEPTH-1])
    else $error("scan ended without a candidate");

  // Count never passes capacity
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("entry count above capacity");

  // A scan only runs on a non-empty queue
  a_scan_nonempty: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN |-> count != '0)
    else $error("scan on empty queue");

  // A successful insert grows the count by one
  a_insert_count: assert property (@(posedge clk) disable iff (rst)
    ins_go |=> count == $past(count) + 1'b1)
    else $error("insert did not advance count");
`endif

endmodule

FILE: bench/tb_unsorted_array_priority_queue.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_unsorted_array_priority_queue
// Self-checking bench for the unsorted array priority queue. A directed
// sequence covers the empty and full cases, priority extremes, ties and the
// unused request code. A long random sequence follows, leaning in turn
// toward filling, draining and mixed traffic. Each accepted request is run
// through a local model of the queue. Each response is checked field by
// field against the oldest predicted answer. Sender bursts and receiver
// stalls are random.
// ----------------------------------------------------------------------------
module tb_unsorted_array_priority_queue;
  import upaq_pkg::*;

  localparam int DEPTH = DEPTH_DEF;
  localparam int RANDOM_REQUESTS = 1950;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  // Model of the queue contents, in arrival order
  logic signed [31:0] held_value [DEPTH];
  logic signed [15:0] held_priority [DEPTH];
  int held_count = 0;

  req_t pending_requests[$];
  rsp_t pending_answers[$];
  int error_count = 0;

  // Sender burst and gap bookkeeping
  int burst_left = 0;
  int gap_left = 0;

  // Receiver stall pattern
  logic [15:0] ready_pattern = 16'hffff;
  int pattern_age = 0;

  unsorted_array_priority_queue u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  always #4 clk = ~clk;

  // Print one mismatch line and count it
  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    error_count++;
    $display("%0t ns: %s mismatch: got %h, want %h", $time, what, got, want);
  endtask

  function automatic req_t make_request(logic [1:0] kind, logic [31:0] value,
                                        logic [15:0] priority_val);
    req_t r;
    r.kind = kind;
    r.in_value = value;
    r.in_priority = priority_val;
    return r;
  endfunction

  // Apply one request to the model and return the answer it must produce
  function automatic rsp_t serve_request(req_t r);
    rsp_t answer;
    int best;
    answer = '0;
    case (r.kind)
      KIND_INSERT: begin
        if (held_count >= DEPTH) begin
          answer.status = ST_FULL;
        end else begin
          held_value[held_count] = r.in_value;
          held_priority[held_count] = r.in_priority;
          held_count++;
        end
      end
      KIND_REMOVE, KIND_PEEK: begin
        if (held_count == 0) begin
          answer.status = ST_EMPTY;
        end else begin
          // strict compare keeps the earliest entry on ties
          best = 0;
          for (int i = 1; i < held_count; i++) begin
            if (held_priority[i] > held_priority[best]) best = i;
          end
          answer.out_value = held_value[best];
          if (r.kind == KIND_REMOVE) begin
            for (int i = best; i + 1 < held_count; i++) begin
              held_value[i] = held_value[i + 1];
              held_priority[i] = held_priority[i + 1];
            end
            held_count--;
          end
        end
      end
      default: ;
    endcase
    answer.entry_count = held_count[3:0];
    answer.is_empty = (held_count == 0);
    return answer;
  endfunction

  // Driver: present queued requests in bursts, predict each accepted one
  always @(posedge clk) begin
    logic take;
    logic next_valid;
    req_t next_req;
    take = req_valid && req_ready;
    next_valid = req_valid;
    next_req = req;
    if (!rst) begin
      if (take) pending_answers.push_back(serve_request(req));
      if (!req_valid || take) begin
        next_valid = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_requests.size() > 0) begin
          next_req = pending_requests.pop_front();
          next_valid = 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            // pick the next burst; some run long with no gap at all
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 12);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end
        end
      end
    end
    req_valid <= rst ? 1'b0 : next_valid;
    req <= next_req;
  end

  // Monitor: check each response, then advance the stall pattern
  always @(posedge clk) begin
    rsp_t want;
    logic [15:0] next_pattern;
    int next_age;
    next_pattern = {ready_pattern[14:0], ready_pattern[15]};
    next_age = pattern_age + 1;
    if (!rst) begin
      if (rsp_valid && rsp_ready) begin
        if (pending_answers.size() == 0) begin
          report_mismatch("unexpected response", rsp.out_value, '0);
        end else begin
          want = pending_answers.pop_front();
          if (rsp.status !== want.status)
            report_mismatch("status", 32'(rsp.status), 32'(want.status));
          if (rsp.out_value !== want.out_value)
            report_mismatch("out_value", rsp.out_value, want.out_value);
          if (rsp.entry_count !== want.entry_count)
            report_mismatch("entry_count", 32'(rsp.entry_count),
                            32'(want.entry_count));
          if (rsp.is_empty !== want.is_empty)
            report_mismatch("is_empty", 32'(rsp.is_empty), 32'(want.is_empty));
        end
      end
      // switch stall style when the pattern age counter wraps: none, heavy or light
      if (pattern_age >= 63) begin
        next_age = 0;
        case ($urandom_range(0, 2))
          0: next_pattern = 16'hffff;
          1: next_pattern = 16'($urandom());
          default: next_pattern = 16'($urandom() | $urandom());
        endcase
      end
    end
    ready_pattern <= next_pattern;
    pattern_age <= next_age;
    rsp_ready <= rst ? 1'b0 : next_pattern[0];
  end

  initial begin
    logic [1:0] kind;
    logic [31:0] value;
    logic [15:0] priority_val;
    int counted;
    int lean;
    int run_left;
    int roll;
    int insert_limit;

    // Directed: empty queue, unused code, extremes, ties, full, drain
    pending_requests.push_back(make_request(KIND_PEEK, 32'h1234_5678, 16'h0001));
    pending_requests.push_back(make_request(KIND_REMOVE, 32'hffff_ffff, 16'hffff));
    pending_requests.push_back(make_request(KIND_UNUSED, 32'hdead_beef, 16'h7fff));
    pending_requests.push_back(make_request(KIND_INSERT, 32'h8000_0000, 16'h8000));
    pending_requests.push_back(make_request(KIND_INSERT, 32'h7fff_ffff, 16'h7fff));
    pending_requests.push_back(make_request(KIND_INSERT, 32'h0000_0000, 16'h0000));
    pending_requests.push_back(make_request(KIND_INSERT, 32'h0000_0005, 16'd100));
    pending_requests.push_back(make_request(KIND_INSERT, 32'h0000_0006, 16'd100));
    pending_requests.push_back(make_request(KIND_INSERT, 32'hffff_ffff, 16'hffff));
    pending_requests.push_back(make_request(KIND_INSERT, 32'h0000_0007, 16'h7fff));
    pending_requests.push_back(make_request(KIND_INSERT, 32'h0000_0008, 16'd100));
    pending_requests.push_back(make_request(KIND_INSERT, 32'h5555_aaaa, 16'h7fff));
    pending_requests.push_back(make_request(KIND_PEEK, 32'h0, 16'h0));
    pending_requests.push_back(make_request(KIND_UNUSED, 32'hffff_ffff, 16'hffff));
    for (int i = 0; i < DEPTH; i++) begin
      pending_requests.push_back(make_request(KIND_REMOVE, 32'h0, 16'h0));
    end
    pending_requests.push_back(make_request(KIND_REMOVE, 32'h0, 16'h0));

    // Random: runs that lean toward filling, draining or a mix
    counted = 0;
    run_left = 0;
    lean = 0;
    while (counted < RANDOM_REQUESTS) begin
      if (run_left == 0) begin
        lean = $urandom_range(0, 2);
        run_left = $urandom_range(10, 60);
      end
      run_left--;
      case (lean)
        0: insert_limit = 78;
        1: insert_limit = 40;
        default: insert_limit = 59;
      endcase
      roll = $urandom_range(0, 99);
      if (roll < 3) kind = KIND_UNUSED;
      else if (roll < 18) kind = KIND_PEEK;
      else if (roll < insert_limit) kind = KIND_INSERT;
      else kind = KIND_REMOVE;

      roll = $urandom_range(0, 9);
      if (roll == 0) value = $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
      else value = $urandom();

      // narrow priorities make ties common
      roll = $urandom_range(0, 9);
      if (roll < 4) priority_val = 16'($urandom_range(0, 3)) - 16'd1;
      else if (roll == 4) priority_val = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
      else priority_val = 16'($urandom());

      pending_requests.push_back(make_request(kind, value, priority_val));
      if (kind != KIND_UNUSED) counted++;
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Hold until every request is taken and every answer has come back
    while (pending_requests.size() > 0 || req_valid || pending_answers.size() > 0)
      @(posedge clk);
    repeat (2 * DEPTH + 4) @(posedge clk);

    if (error_count == 0) begin
      $display("tb_unsorted_array_priority_queue: done, clean");
    end else begin
      $display("tb_unsorted_array_priority_queue: done, errors");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #4_000_000;
    $display("tb_unsorted_array_priority_queue: done, errors");
    $finish;
  end

endmodule
